/* src/dplm_pkg.sv */
// Package for the decaying peak level meter: widths, register reset values,
// register index codes, zone codes and the controller/datapath interface types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package dplm_pkg;

  // Field widths.
  localparam int LEVEL_BITS    = 16;
  localparam int LENGTH_BITS   = 12;
  localparam int COEF_BITS     = 16;
  localparam int BRIGHT_BITS   = 8;
  localparam int ZONE_BITS     = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 4;

  // Shared multiplier: level by coefficient, the widest product.
  localparam int MUL_BITS = LEVEL_BITS + COEF_BITS;

  // Pixel product meter_length * level, and the divider that splits it.
  // quotient = (prod >> DIV_SHIFT) / seg gives lit segments above
  // BRIGHT_BITS fraction bits, which are the partial brightness.
  localparam int POS_BITS      = LENGTH_BITS + LEVEL_BITS;
  localparam int DIV_SHIFT     = LEVEL_BITS - 1 - BRIGHT_BITS;
  localparam int DIVIDEND_BITS = POS_BITS - DIV_SHIFT;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = LEVEL_BITS'(1) << (LEVEL_BITS - 1);
  localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = LENGTH_BITS'(1);

  // Register reset values.
  localparam logic [COEF_BITS-1:0]   RST_FALLOFF_SLOW    = 16'd62259;
  localparam logic [COEF_BITS-1:0]   RST_FALLOFF_FAST    = 16'd52429;
  localparam logic [LEVEL_BITS-1:0]  RST_FAST_KNEE       = 16'd6554;
  localparam logic [LEVEL_BITS-1:0]  RST_FLOOR_LEVEL     = 16'd328;
  localparam logic [LENGTH_BITS-1:0] RST_METER_LENGTH    = 12'd256;
  localparam logic [LENGTH_BITS-1:0] RST_SEGMENT_SIZE    = 12'd8;
  localparam logic [COEF_BITS-1:0]   RST_ORANGE_FRACTION = 16'd39322;
  localparam logic [COEF_BITS-1:0]   RST_RED_FRACTION    = 16'd60949;

  // Register index codes.
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF_SLOW    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF_FAST    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_KNEE       = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR_LEVEL     = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_METER_LENGTH    = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_SIZE    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORANGE_FRACTION = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_RED_FRACTION    = 4'd7;

  // Colour zone codes.
  localparam logic [ZONE_BITS-1:0] ZONE_GREEN  = 2'd0;
  localparam logic [ZONE_BITS-1:0] ZONE_ORANGE = 2'd1;
  localparam logic [ZONE_BITS-1:0] ZONE_RED    = 2'd2;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_POS,
    MUL_RED,
    MUL_ORANGE
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_smooth;
    logic     div_load_pos;
    logic     div_load_full;
    logic     div_step;
    logic     save_quo;
    logic     save_red;
    logic     write_out;
  } dplm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dplm_stat_t;

endpackage

/* src/dplm_div.sv */
// Restoring serial divider, one quotient bit per step, for the level meter.
// Depends on dplm_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module dplm_div
  import dplm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [LENGTH_BITS-1:0]   divisor_i,
  output logic [DIVIDEND_BITS-1:0] quotient_o
);

  logic [DIVIDEND_BITS-1:0] dq_q, dq_d;
  logic [LENGTH_BITS-1:0]   rem_q, rem_d;
  logic [LENGTH_BITS-1:0]   dvs_q;
  logic [LENGTH_BITS:0]     trial;
  logic [LENGTH_BITS:0]     diff;
  logic                     fits;

  // One shift-and-subtract step; the dividend register fills with quotient bits.
  always_comb begin
    trial = {rem_q, dq_q[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
    dq_d  = {dq_q[DIVIDEND_BITS-2:0], fits};
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dq_q;

endmodule

/* src/dplm_datapath.sv */
// Datapath of the level meter: configuration registers, level state, the shared
// multiplier, the serial divider and the output register. Depends on dplm_pkg
// and dplm_div.
`timescale 1ns / 1ps

module dplm_datapath
  import dplm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [LEVEL_BITS-1:0]    level_in_i,
  input  dplm_cmd_t                cmd_i,
  output dplm_stat_t               stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [LEVEL_BITS-1:0]    smoothed_level_o,
  output logic [LEVEL_BITS-1:0]    peak_level_o,
  output logic [LENGTH_BITS-1:0]   lit_segments_o,
  output logic [BRIGHT_BITS-1:0]   last_brightness_o,
  output logic [ZONE_BITS-1:0]     last_zone_o
);

  logic [COEF_BITS-1:0]   falloff_slow_q, falloff_fast_q, orange_fraction_q, red_fraction_q;
  logic [LEVEL_BITS-1:0]  fast_knee_q, floor_level_q;
  logic [LENGTH_BITS-1:0] meter_length_q, segment_size_q;

  logic [LEVEL_BITS-1:0]  lvl_q, lvl_d;
  logic [LEVEL_BITS-1:0]  smooth_q, smooth_d;
  logic [LEVEL_BITS-1:0]  peak_q;
  logic [MUL_BITS-1:0]    mul_q;
  logic [LENGTH_BITS-1:0] lit_q;
  logic [BRIGHT_BITS-1:0] bright_q;
  logic                   red_hit_q;

  logic                   out_valid_q;
  logic [LEVEL_BITS-1:0]  out_smooth_q, out_peak_q;
  logic [LENGTH_BITS-1:0] out_lit_q;
  logic [BRIGHT_BITS-1:0] out_bright_q;
  logic [ZONE_BITS-1:0]   out_zone_q;

  logic [LEVEL_BITS-1:0]    mul_a;
  logic [COEF_BITS-1:0]     mul_b;
  logic [LEVEL_BITS-1:0]    decayed, raised, floored;
  logic [LENGTH_BITS-1:0]   seg;
  logic [LENGTH_BITS-1:0]   full;
  logic [DIVIDEND_BITS-1:0] div_dividend;
  logic [DIVIDEND_BITS-1:0] quotient;
  logic [MUL_BITS-1:0]      lit_scaled;
  logic                     orange_hit;
  logic [ZONE_BITS-1:0]     zone;

  // Configuration registers; the length registers keep the low bits of the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falloff_slow_q    <= RST_FALLOFF_SLOW;
      falloff_fast_q    <= RST_FALLOFF_FAST;
      fast_knee_q       <= RST_FAST_KNEE;
      floor_level_q     <= RST_FLOOR_LEVEL;
      meter_length_q    <= RST_METER_LENGTH;
      segment_size_q    <= RST_SEGMENT_SIZE;
      orange_fraction_q <= RST_ORANGE_FRACTION;
      red_fraction_q    <= RST_RED_FRACTION;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FALLOFF_SLOW:    falloff_slow_q    <= cfg_data_i;
        REG_FALLOFF_FAST:    falloff_fast_q    <= cfg_data_i;
        REG_FAST_KNEE:       fast_knee_q       <= cfg_data_i;
        REG_FLOOR_LEVEL:     floor_level_q     <= cfg_data_i;
        REG_METER_LENGTH:    meter_length_q    <= cfg_data_i[LENGTH_BITS-1:0];
        REG_SEGMENT_SIZE:    segment_size_q    <= cfg_data_i[LENGTH_BITS-1:0];
        REG_ORANGE_FRACTION: orange_fraction_q <= cfg_data_i;
        REG_RED_FRACTION:    red_fraction_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input clamp to full scale.
  assign lvl_d = (level_in_i > FULL_SCALE) ? FULL_SCALE : level_in_i;

  // Shared multiplier operand selection.
  assign full = quotient[LENGTH_BITS-1:0];
  always_comb begin
    mul_a = smooth_q;
    mul_b = (smooth_q < fast_knee_q) ? falloff_fast_q : falloff_slow_q;
    case (cmd_i.mul_sel)
      MUL_DECAY: begin
        mul_a = smooth_q;
        mul_b = (smooth_q < fast_knee_q) ? falloff_fast_q : falloff_slow_q;
      end
      MUL_POS: begin
        mul_a = smooth_q;
        mul_b = COEF_BITS'(meter_length_q);
      end
      MUL_RED: begin
        mul_a = red_fraction_q;
        mul_b = COEF_BITS'(full);
      end
      MUL_ORANGE: begin
        mul_a = orange_fraction_q;
        mul_b = COEF_BITS'(full);
      end
      default: ;
    endcase
  end

  // Smoothed level update: instant attack, else decay, raise and floor.
  always_comb begin
    decayed  = mul_q[MUL_BITS-1:COEF_BITS];
    raised   = (lvl_q > decayed) ? lvl_q : decayed;
    floored  = (raised < floor_level_q) ? '0 : raised;
    smooth_d = (lvl_q > smooth_q) ? lvl_q : floored;
  end

  // Level state and multiplier result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      peak_q   <= '0;
    end else if (cmd_i.upd_smooth) begin
      smooth_q <= smooth_d;
      if (lvl_q > peak_q) begin
        peak_q <= lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lvl_q <= lvl_d;
    end
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Divider: first the pixel product by the segment size, then the bar length.
  assign seg = (segment_size_q == '0) ? LENGTH_ONE : segment_size_q;
  assign div_dividend = cmd_i.div_load_full
                      ? {meter_length_q, {(DIVIDEND_BITS - LENGTH_BITS){1'b0}}}
                      : mul_q[POS_BITS-1:DIV_SHIFT];

  dplm_div u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load_pos | cmd_i.div_load_full),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_dividend),
    .divisor_i  (seg),
    .quotient_o (quotient)
  );

  // Zone comparisons against the scaled thresholds.
  assign lit_scaled = MUL_BITS'({lit_q, {COEF_BITS{1'b0}}});
  assign orange_hit = (lit_scaled > mul_q);
  assign zone = red_hit_q ? ZONE_RED : (orange_hit ? ZONE_ORANGE : ZONE_GREEN);

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_quo) begin
      lit_q    <= quotient[BRIGHT_BITS +: LENGTH_BITS];
      bright_q <= quotient[BRIGHT_BITS-1:0];
    end
    if (cmd_i.save_red) begin
      red_hit_q <= (lit_scaled > mul_q);
    end
  end

  // Output register; it holds a result until the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_smooth_q <= smooth_q;
      out_peak_q   <= peak_q;
      out_lit_q    <= lit_q;
      out_bright_q <= bright_q;
      out_zone_q   <= zone;
    end
  end

  assign stat_o.out_busy    = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign smoothed_level_o   = out_smooth_q;
  assign peak_level_o       = out_peak_q;
  assign lit_segments_o     = out_lit_q;
  assign last_brightness_o  = out_bright_q;
  assign last_zone_o        = out_zone_q;

endmodule

/* src/dplm_ctrl.sv */
// Controller of the level meter: steps each item through decay, position,
// two divisions and the zone compares. Depends on dplm_pkg.
`timescale 1ns / 1ps

module dplm_ctrl
  import dplm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dplm_stat_t stat_i,
  output dplm_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECAY   = 4'd1;
  localparam logic [3:0] S_UPDATE  = 4'd2;
  localparam logic [3:0] S_POS     = 4'd3;
  localparam logic [3:0] S_LDPOS   = 4'd4;
  localparam logic [3:0] S_DIVPOS  = 4'd5;
  localparam logic [3:0] S_LDFULL  = 4'd6;
  localparam logic [3:0] S_DIVFULL = 4'd7;
  localparam logic [3:0] S_ZRED    = 4'd8;
  localparam logic [3:0] S_ZORANGE = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  localparam logic [DIV_CNT_BITS-1:0] POS_STEPS_M1  = DIV_CNT_BITS'(DIVIDEND_BITS - 1);
  localparam logic [DIV_CNT_BITS-1:0] FULL_STEPS_M1 = DIV_CNT_BITS'(LENGTH_BITS - 1);

  logic [3:0]              state_q, state_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECAY;
        end
      end
      S_DECAY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DECAY;
        state_d       = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.upd_smooth = 1'b1;
        state_d          = S_POS;
      end
      S_POS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_POS;
        state_d       = S_LDPOS;
      end
      S_LDPOS: begin
        cmd_o.div_load_pos = 1'b1;
        cnt_d              = POS_STEPS_M1;
        state_d            = S_DIVPOS;
      end
      S_DIVPOS: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LDFULL;
        end
      end
      S_LDFULL: begin
        cmd_o.save_quo      = 1'b1;
        cmd_o.div_load_full = 1'b1;
        cnt_d               = FULL_STEPS_M1;
        state_d             = S_DIVFULL;
      end
      S_DIVFULL: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_ZRED;
        end
      end
      S_ZRED: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RED;
        state_d       = S_ZORANGE;
      end
      S_ZORANGE: begin
        cmd_o.save_red = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_ORANGE;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.write_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* src/decaying_peak_level_meter.sv */
// Decaying peak level meter with bar-graph output (top level).
//
// Input channel: in_valid_i / in_ready_o carry one Q1.15 level per transaction.
// Output channel: out_valid_o / out_ready_i carry one result per input: the
// smoothed level, the peak hold, the lit segment count, the partial brightness
// of the final segment and its colour zone.
// Configuration: a write at cfg_we_i stores cfg_data_i into register cfg_idx_i;
// indexes beyond the eight registers are ignored. Write only while idle.
// A new input is accepted only in the idle state, once the previous item has
// been written to the output register. Each item passes the multiplier once
// each for the decay, the pixel position and the two zone thresholds, and the
// serial divider takes 21 steps for the segment count and brightness and 12
// steps for the full-scale segment count.
// A finished result waits in the output register while the receiver stalls;
// the next input is accepted meanwhile and is held at its final step until
// the output register frees up.
// Reset clears the smoothed level and the peak hold, loads the register
// defaults and empties the output register.
// Depends on dplm_pkg, dplm_ctrl, dplm_datapath and dplm_div.
`timescale 1ns / 1ps

module decaying_peak_level_meter
  import dplm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [LEVEL_BITS-1:0]    level_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [LEVEL_BITS-1:0]    smoothed_level_o,
  output logic [LEVEL_BITS-1:0]    peak_level_o,
  output logic [LENGTH_BITS-1:0]   lit_segments_o,
  output logic [BRIGHT_BITS-1:0]   last_brightness_o,
  output logic [ZONE_BITS-1:0]     last_zone_o
);

  dplm_cmd_t  cmd;
  dplm_stat_t stat;

  // Sequencer.
  dplm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic, state and output register.
  dplm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .level_in_i        (level_in_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .smoothed_level_o  (smoothed_level_o),
    .peak_level_o      (peak_level_o),
    .lit_segments_o    (lit_segments_o),
    .last_brightness_o (last_brightness_o),
    .last_zone_o       (last_zone_o)
  );

endmodule
